/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("ASSERT_ALWAYS failed");

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ASSERT_IMPLIES failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, cond)

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)

`endif

`endif

/* rtl/pfe_pkg.sv */
package pfe_pkg;

    localparam int SQUARE_SIDE  = 5;
    localparam int SQUARE_CELLS = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTER_COUNT = 26;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [6:0] CIPHER_BASE   = 7'h41;

    typedef enum logic [2:0] {
        OP_BEGIN_KEY  = 3'd0,
        OP_KEY_CHAR   = 3'd1,
        OP_CLOSE_KEY  = 3'd2,
        OP_TEXT_CHAR  = 3'd3,
        OP_END_TEXT   = 3'd4
    } pfe_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SEARCH,
        ST_CALC,
        ST_RD1,
        ST_PUT1,
        ST_RD2,
        ST_PUT2
    } pfe_state_t;

    function automatic logic [2:0] wrap_inc(input logic [2:0] pos);
        logic [2:0] res;
        if (pos == 3'(SQUARE_SIDE - 1)) begin
            res = 3'd0;
        end else begin
            res = pos + 3'd1;
        end
        return res;
    endfunction

    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        logic [4:0] base;
        base = ({2'b00, row} << 2) + {2'b00, row};
        return base + {2'b00, col};
    endfunction

endpackage

/* rtl/playfair_digraph_encryptor_core.sv */
// Playfair encryptor over a 5x5 key square held in a small two-port memory.
// Input channel: s_axis_tuser carries the operation, s_axis_tdata the ASCII byte.
// Output channel: m_axis_tdata carries one cipher letter, m_axis_tlast marks the
// second letter of each enciphered pair.
// begin_key, key_char and plain text letters that only open a pair never leave idle.
// close_key walks the 26 letters, one a cycle.
// A completed pair scans the filled part of the square, one entry a cycle through
// the memory read port, then reads the two cipher letters back from the same port.
// The input is not ready while close_key or a pair is being worked on.
// Calc, read and put states follow the scan to load the first letter; the output
// register lets the block take the next item while the last letter still waits.
// If the receiver stalls, the sequencer holds before loading the next letter.
// After reset the letter set holds only J, the square is empty and no letter
// is pending; the square contents are unknown until written.
`include "assert_macros.svh"

module playfair_digraph_encryptor_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] character
    input  logic [2:0] s_axis_tuser,   // [2:0] operation
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] cipher_letter, [7] zero
    output logic       m_axis_tlast
);

    pfe_pkg::pfe_state_t state_reg, state_next;

    logic [25:0] letter_used_reg, letter_used_next;
    logic [4:0]  fill_count_reg, fill_count_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [4:0]  pend_letter_reg, pend_letter_next;
    logic [4:0]  fill_k_reg, fill_k_next;
    logic [4:0]  let_a_reg, let_a_next;
    logic [4:0]  let_b_reg, let_b_next;
    logic [4:0]  scan_reg, scan_next;
    logic [2:0]  scan_row_reg, scan_row_next;
    logic [2:0]  scan_col_reg, scan_col_next;
    logic        cmp_valid_reg, cmp_valid_next;
    logic [2:0]  cmp_row_reg, cmp_row_next;
    logic [2:0]  cmp_col_reg, cmp_col_next;
    logic        found_a_reg, found_a_next;
    logic        found_b_reg, found_b_next;
    logic [2:0]  row_a_reg, row_a_next;
    logic [2:0]  col_a_reg, col_a_next;
    logic [2:0]  row_b_reg, row_b_next;
    logic [2:0]  col_b_reg, col_b_next;
    logic [4:0]  tgt1_reg, tgt1_next;
    logic [4:0]  tgt2_reg, tgt2_next;
    logic        m_valid_reg, m_valid_next;
    logic [6:0]  m_letter_reg, m_letter_next;
    logic        m_last_reg, m_last_next;

    logic [4:0]  square_mem [0:pfe_pkg::SQUARE_CELLS-1];
    logic [4:0]  rd_data_reg;
    logic        wr_en;
    logic [4:0]  wr_addr;
    logic [4:0]  wr_data;
    logic [4:0]  rd_addr;

    logic        in_is_letter;
    logic [4:0]  in_idx;
    logic [4:0]  text_idx;
    logic        square_full;
    logic        start_pair;
    logic [4:0]  pair_a;
    logic [4:0]  pair_b;
    logic        out_free;

    always_comb begin
        in_is_letter = 1'b0;
        in_idx       = 5'd0;
        if (s_axis_tdata inside {[pfe_pkg::ASCII_UPPER_A:pfe_pkg::ASCII_UPPER_Z]}) begin
            in_is_letter = 1'b1;
            in_idx       = 5'(s_axis_tdata - pfe_pkg::ASCII_UPPER_A);
        end else if (s_axis_tdata inside
                     {[pfe_pkg::ASCII_LOWER_A:pfe_pkg::ASCII_LOWER_Z]}) begin
            in_is_letter = 1'b1;
            in_idx       = 5'(s_axis_tdata - pfe_pkg::ASCII_LOWER_A);
        end
        text_idx = (in_idx == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : in_idx;
    end

    assign square_full   = (fill_count_reg >= 5'(pfe_pkg::SQUARE_CELLS));
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == pfe_pkg::ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        letter_used_next = letter_used_reg;
        fill_count_next  = fill_count_reg;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        fill_k_next      = fill_k_reg;
        let_a_next       = let_a_reg;
        let_b_next       = let_b_reg;
        scan_next        = scan_reg;
        scan_row_next    = scan_row_reg;
        scan_col_next    = scan_col_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_row_next     = cmp_row_reg;
        cmp_col_next     = cmp_col_reg;
        found_a_next     = found_a_reg;
        found_b_next     = found_b_reg;
        row_a_next       = row_a_reg;
        col_a_next       = col_a_reg;
        row_b_next       = row_b_reg;
        col_b_next       = col_b_reg;
        tgt1_next        = tgt1_reg;
        tgt2_next        = tgt2_reg;
        m_valid_next     = m_valid_reg;
        m_letter_next    = m_letter_reg;
        m_last_next      = m_last_reg;
        wr_en            = 1'b0;
        wr_addr          = fill_count_reg;
        wr_data          = in_idx;
        rd_addr          = 5'd0;
        start_pair       = 1'b0;
        pair_a           = pend_letter_reg;
        pair_b           = pfe_pkg::LETTER_X;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            pfe_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (pfe_pkg::pfe_op_t'(s_axis_tuser))
                        pfe_pkg::OP_BEGIN_KEY: begin
                            letter_used_next = 26'd1 << pfe_pkg::LETTER_J;
                            fill_count_next  = 5'd0;
                            pend_valid_next  = 1'b0;
                            pend_letter_next = 5'd0;
                        end
                        pfe_pkg::OP_KEY_CHAR: begin
                            if (in_is_letter && in_idx != pfe_pkg::LETTER_J &&
                                !letter_used_reg[in_idx] && !square_full) begin
                                wr_en            = 1'b1;
                                fill_count_next  = fill_count_reg + 5'd1;
                                letter_used_next = letter_used_reg | (26'd1 << in_idx);
                            end
                        end
                        pfe_pkg::OP_CLOSE_KEY: begin
                            fill_k_next = 5'd0;
                            state_next  = pfe_pkg::ST_FILL;
                        end
                        pfe_pkg::OP_TEXT_CHAR: begin
                            if (in_is_letter) begin
                                if (!pend_valid_reg) begin
                                    pend_valid_next  = 1'b1;
                                    pend_letter_next = text_idx;
                                end else begin
                                    start_pair = 1'b1;
                                    if (text_idx != pend_letter_reg) begin
                                        pair_b           = text_idx;
                                        pend_valid_next  = 1'b0;
                                        pend_letter_next = 5'd0;
                                    end
                                end
                            end
                        end
                        pfe_pkg::OP_END_TEXT: begin
                            if (pend_valid_reg) begin
                                start_pair       = 1'b1;
                                pend_valid_next  = 1'b0;
                                pend_letter_next = 5'd0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (start_pair) begin
                    let_a_next     = pair_a;
                    let_b_next     = pair_b;
                    scan_next      = 5'd0;
                    scan_row_next  = 3'd0;
                    scan_col_next  = 3'd0;
                    cmp_valid_next = 1'b0;
                    found_a_next   = 1'b0;
                    found_b_next   = 1'b0;
                    row_a_next     = 3'd0;
                    col_a_next     = 3'd0;
                    row_b_next     = 3'd0;
                    col_b_next     = 3'd0;
                    state_next     = pfe_pkg::ST_SEARCH;
                end
            end
            pfe_pkg::ST_FILL: begin
                wr_data = fill_k_reg;
                if (!letter_used_reg[fill_k_reg] && !square_full) begin
                    wr_en            = 1'b1;
                    fill_count_next  = fill_count_reg + 5'd1;
                    letter_used_next = letter_used_reg | (26'd1 << fill_k_reg);
                end
                if (fill_k_reg == 5'(pfe_pkg::LETTER_COUNT - 1)) begin
                    state_next = pfe_pkg::ST_IDLE;
                end else begin
                    fill_k_next = fill_k_reg + 5'd1;
                end
            end
            pfe_pkg::ST_SEARCH: begin
                if (cmp_valid_reg) begin
                    if (!found_a_reg && rd_data_reg == let_a_reg) begin
                        found_a_next = 1'b1;
                        row_a_next   = cmp_row_reg;
                        col_a_next   = cmp_col_reg;
                    end
                    if (!found_b_reg && rd_data_reg == let_b_reg) begin
                        found_b_next = 1'b1;
                        row_b_next   = cmp_row_reg;
                        col_b_next   = cmp_col_reg;
                    end
                end
                if (scan_reg < fill_count_reg) begin
                    rd_addr        = scan_reg;
                    cmp_valid_next = 1'b1;
                    cmp_row_next   = scan_row_reg;
                    cmp_col_next   = scan_col_reg;
                    scan_next      = scan_reg + 5'd1;
                    scan_col_next  = pfe_pkg::wrap_inc(scan_col_reg);
                    if (scan_col_reg == 3'(pfe_pkg::SQUARE_SIDE - 1)) begin
                        scan_row_next = scan_row_reg + 3'd1;
                    end
                end else begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg) begin
                        state_next = pfe_pkg::ST_CALC;
                    end
                end
            end
            pfe_pkg::ST_CALC: begin
                if (row_a_reg == row_b_reg) begin
                    tgt1_next = pfe_pkg::cell_addr(row_a_reg, pfe_pkg::wrap_inc(col_a_reg));
                    tgt2_next = pfe_pkg::cell_addr(row_b_reg, pfe_pkg::wrap_inc(col_b_reg));
                end else if (col_a_reg == col_b_reg) begin
                    tgt1_next = pfe_pkg::cell_addr(pfe_pkg::wrap_inc(row_a_reg), col_a_reg);
                    tgt2_next = pfe_pkg::cell_addr(pfe_pkg::wrap_inc(row_b_reg), col_b_reg);
                end else begin
                    tgt1_next = pfe_pkg::cell_addr(row_a_reg, col_b_reg);
                    tgt2_next = pfe_pkg::cell_addr(row_b_reg, col_a_reg);
                end
                state_next = pfe_pkg::ST_RD1;
            end
            pfe_pkg::ST_RD1: begin
                rd_addr    = tgt1_reg;
                state_next = pfe_pkg::ST_PUT1;
            end
            pfe_pkg::ST_PUT1: begin
                rd_addr = tgt1_reg;
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_letter_next = pfe_pkg::CIPHER_BASE + {2'b00, rd_data_reg};
                    m_last_next   = 1'b0;
                    state_next    = pfe_pkg::ST_RD2;
                end
            end
            pfe_pkg::ST_RD2: begin
                rd_addr    = tgt2_reg;
                state_next = pfe_pkg::ST_PUT2;
            end
            pfe_pkg::ST_PUT2: begin
                rd_addr = tgt2_reg;
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_letter_next = pfe_pkg::CIPHER_BASE + {2'b00, rd_data_reg};
                    m_last_next   = 1'b1;
                    state_next    = pfe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pfe_pkg::ST_IDLE;
            letter_used_reg <= 26'd1 << pfe_pkg::LETTER_J;
            fill_count_reg  <= 5'd0;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= 5'd0;
            fill_k_reg      <= 5'd0;
            scan_reg        <= 5'd0;
            scan_row_reg    <= 3'd0;
            scan_col_reg    <= 3'd0;
            cmp_valid_reg   <= 1'b0;
            found_a_reg     <= 1'b0;
            found_b_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            letter_used_reg <= letter_used_next;
            fill_count_reg  <= fill_count_next;
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
            fill_k_reg      <= fill_k_next;
            scan_reg        <= scan_next;
            scan_row_reg    <= scan_row_next;
            scan_col_reg    <= scan_col_next;
            cmp_valid_reg   <= cmp_valid_next;
            found_a_reg     <= found_a_next;
            found_b_reg     <= found_b_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        let_a_reg    <= let_a_next;
        let_b_reg    <= let_b_next;
        cmp_row_reg  <= cmp_row_next;
        cmp_col_reg  <= cmp_col_next;
        row_a_reg    <= row_a_next;
        col_a_reg    <= col_a_next;
        row_b_reg    <= row_b_next;
        col_b_reg    <= col_b_next;
        tgt1_reg     <= tgt1_next;
        tgt2_reg     <= tgt2_next;
        m_letter_reg <= m_letter_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            square_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= square_mem[rd_addr];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_letter_reg};
    assign m_axis_tlast  = m_last_reg;

    `ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_count_reg <= 5'(pfe_pkg::SQUARE_CELLS))
    `ASSERT_ALWAYS(a_j_kept_out, aclk, aresetn, letter_used_reg[pfe_pkg::LETTER_J])
    `ASSERT_IMPLIES(a_scan_bound, aclk, aresetn, state_reg == pfe_pkg::ST_SEARCH, scan_reg <= fill_count_reg)
    `ASSERT_IMPLIES(a_out_from_put, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == pfe_pkg::ST_PUT1 || $past(state_reg) == pfe_pkg::ST_PUT2)

endmodule
